### rtl/pfj_pkg.sv
// Shared constants, types and the microcode program of the Jacobian fill block.
// Used by pfj_ctrl, pfj_datapath and power_flow_jacobian_fill.
package pfj_pkg;

    localparam int VALUE_WIDTH = 48;
    localparam int SLOT_BITS   = 24;
    localparam int SLOT_W      = SLOT_BITS + 1;
    localparam int FRAC        = 28;
    localparam int MAG_FLOOR   = 3;

    // multiplier: one DIG-bit digit of |a| times |b| per cycle
    localparam int DIG    = 16;
    localparam int NDIG   = (VALUE_WIDTH + DIG - 1) / DIG;
    localparam int MAW    = NDIG * DIG;
    localparam int PACC_W = MAW + VALUE_WIDTH;
    localparam int ACC_W  = PACC_W + 2;

    // divider: quotient of |c| * 2^FRAC / |V| stays below 2^(FRAC+1)
    localparam int QB    = FRAC + 1;
    localparam int DV_W  = VALUE_WIDTH + FRAC + 1;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    localparam int PROG_LEN = 50;
    localparam int PC_W     = $clog2(PROG_LEN);
    localparam logic [PC_W-1:0] ELEM_PC = PC_W'(0);
    localparam logic [PC_W-1:0] ROW_PC  = PC_W'(31);

    typedef enum logic [4:0] {
        SRC_VIR, SRC_VII, SRC_VJR, SRC_VJI, SRC_YR, SRC_YI,
        SRC_NR, SRC_NI, SRC_WR, SRC_WI, SRC_UR, SRC_UI,
        SRC_IR, SRC_II, SRC_V0, SRC_V1, SRC_V2, SRC_V3
    } src_t;

    typedef enum logic [2:0] {
        K_MUL, K_STORE, K_SQRT, K_DIV, K_CUR, K_CLR, K_OUT
    } uop_kind_t;

    typedef enum logic [1:0] {
        ACC_LOAD, ACC_ADD, ACC_SUB
    } acc_mode_t;

    typedef struct packed {
        uop_kind_t kind;
        src_t      a;
        src_t      b;
        acc_mode_t mode;
        logic      raw;   // exact product, no rounding (squares for |V|)
        logic      neg;   // negate before saturation on store
        src_t      dst;
    } uop_t;

    typedef struct packed {
        logic go;
        logic load;
        uop_t op;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } stat_t;

    function automatic uop_t mk(input uop_kind_t k, input src_t a, input src_t b,
                                input acc_mode_t m, input logic raw, input logic neg,
                                input src_t d);
        uop_t u;
        u.kind = k;
        u.a    = a;
        u.b    = b;
        u.mode = m;
        u.raw  = raw;
        u.neg  = neg;
        u.dst  = d;
        return u;
    endfunction

    function automatic uop_t mul(input src_t a, input src_t b, input acc_mode_t m);
        return mk(K_MUL, a, b, m, 1'b0, 1'b0, SRC_V0);
    endfunction

    function automatic uop_t sq(input src_t a, input acc_mode_t m);
        return mk(K_MUL, a, a, m, 1'b1, 1'b0, SRC_V0);
    endfunction

    function automatic uop_t st(input src_t d, input logic neg);
        return mk(K_STORE, SRC_VIR, SRC_VIR, ACC_LOAD, 1'b0, neg, d);
    endfunction

    function automatic uop_t ctl(input uop_kind_t k, input src_t a, input src_t d);
        return mk(k, a, a, ACC_LOAD, 1'b0, 1'b0, d);
    endfunction

    // element program at ELEM_PC, row-end program at ROW_PC
    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = sq(SRC_VJR, ACC_LOAD);
            6'd1:  u = sq(SRC_VJI, ACC_ADD);
            6'd2:  u = ctl(K_SQRT, SRC_VJR, SRC_NR);
            6'd3:  u = ctl(K_DIV, SRC_VJR, SRC_NR);
            6'd4:  u = ctl(K_DIV, SRC_VJI, SRC_NI);
            6'd5:  u = mul(SRC_YR, SRC_VJR, ACC_LOAD);
            6'd6:  u = mul(SRC_YI, SRC_VJI, ACC_SUB);
            6'd7:  u = st(SRC_WR, 1'b0);
            6'd8:  u = mul(SRC_YR, SRC_VJI, ACC_LOAD);
            6'd9:  u = mul(SRC_YI, SRC_VJR, ACC_ADD);
            6'd10: u = st(SRC_WI, 1'b0);
            6'd11: u = mul(SRC_YR, SRC_NR, ACC_LOAD);
            6'd12: u = mul(SRC_YI, SRC_NI, ACC_SUB);
            6'd13: u = st(SRC_UR, 1'b0);
            6'd14: u = mul(SRC_YR, SRC_NI, ACC_LOAD);
            6'd15: u = mul(SRC_YI, SRC_NR, ACC_ADD);
            6'd16: u = st(SRC_UI, 1'b0);
            6'd17: u = mul(SRC_VII, SRC_WR, ACC_LOAD);
            6'd18: u = mul(SRC_VIR, SRC_WI, ACC_SUB);
            6'd19: u = st(SRC_V0, 1'b0);
            6'd20: u = mul(SRC_VIR, SRC_WR, ACC_LOAD);
            6'd21: u = mul(SRC_VII, SRC_WI, ACC_ADD);
            6'd22: u = st(SRC_V1, 1'b1);
            6'd23: u = mul(SRC_VIR, SRC_UR, ACC_LOAD);
            6'd24: u = mul(SRC_VII, SRC_UI, ACC_ADD);
            6'd25: u = st(SRC_V2, 1'b0);
            6'd26: u = mul(SRC_VII, SRC_UR, ACC_LOAD);
            6'd27: u = mul(SRC_VIR, SRC_UI, ACC_SUB);
            6'd28: u = st(SRC_V3, 1'b0);
            6'd29: u = ctl(K_CUR, SRC_WR, SRC_IR);
            6'd30: u = ctl(K_OUT, SRC_VIR, SRC_V0);
            6'd31: u = sq(SRC_VIR, ACC_LOAD);
            6'd32: u = sq(SRC_VII, ACC_ADD);
            6'd33: u = ctl(K_SQRT, SRC_VIR, SRC_NR);
            6'd34: u = ctl(K_DIV, SRC_VIR, SRC_NR);
            6'd35: u = ctl(K_DIV, SRC_VII, SRC_NI);
            6'd36: u = mul(SRC_VIR, SRC_II, ACC_LOAD);
            6'd37: u = mul(SRC_VII, SRC_IR, ACC_SUB);
            6'd38: u = st(SRC_V0, 1'b0);
            6'd39: u = mul(SRC_VIR, SRC_IR, ACC_LOAD);
            6'd40: u = mul(SRC_VII, SRC_II, ACC_ADD);
            6'd41: u = st(SRC_V1, 1'b0);
            6'd42: u = mul(SRC_IR, SRC_NR, ACC_LOAD);
            6'd43: u = mul(SRC_II, SRC_NI, ACC_ADD);
            6'd44: u = st(SRC_V2, 1'b0);
            6'd45: u = mul(SRC_IR, SRC_NI, ACC_LOAD);
            6'd46: u = mul(SRC_II, SRC_NR, ACC_SUB);
            6'd47: u = st(SRC_V3, 1'b0);
            6'd48: u = ctl(K_CLR, SRC_IR, SRC_IR);
            default: u = ctl(K_OUT, SRC_VIR, SRC_V0);
        endcase
        return u;
    endfunction

endpackage

### rtl/pfj_ctrl.sv
// Microcode sequencer: takes an item, steps through the program, waits on the datapath.
// Depends on pfj_pkg.
module pfj_ctrl
    import pfj_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  req_type,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} state_t;

    state_t          state_reg;
    logic [PC_W-1:0] pc_reg;
    logic            accept;
    uop_t            op;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign op       = uop_at(pc_reg);

    always_comb
    begin
        cmd.load = accept;
        cmd.op   = op;
        cmd.go   = (state_reg == S_ISSUE) && ((op.kind != K_OUT) || !stat.out_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= ELEM_PC;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pc_reg    <= req_type ? ROW_PC : ELEM_PC;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    if (cmd.go)
                        state_reg <= (op.kind == K_OUT) ? S_IDLE : S_WAIT;
                end
                S_WAIT:
                begin
                    if (!stat.busy)
                    begin
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= S_ISSUE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/pfj_datapath.sv
// Operand registers, digit-serial multiplier with accumulator, bitwise square root,
// restoring divider, row current and the output register. Depends on pfj_pkg.
module pfj_datapath
    import pfj_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output stat_t                         stat,
    input  logic                          req_type,
    input  logic signed [VALUE_WIDTH-1:0] vi_re,
    input  logic signed [VALUE_WIDTH-1:0] vi_im,
    input  logic signed [VALUE_WIDTH-1:0] vj_re,
    input  logic signed [VALUE_WIDTH-1:0] vj_im,
    input  logic signed [VALUE_WIDTH-1:0] adm_re,
    input  logic signed [VALUE_WIDTH-1:0] adm_im,
    input  logic signed [SLOT_W-1:0]      pos_p_angle,
    input  logic signed [SLOT_W-1:0]      pos_q_angle,
    input  logic signed [SLOT_W-1:0]      pos_p_mag,
    input  logic signed [SLOT_W-1:0]      pos_q_mag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          add_mode,
    output logic signed [VALUE_WIDTH-1:0] p_angle_value,
    output logic signed [VALUE_WIDTH-1:0] q_angle_value,
    output logic signed [VALUE_WIDTH-1:0] p_mag_value,
    output logic signed [VALUE_WIDTH-1:0] q_mag_value,
    output logic signed [SLOT_W-1:0]      slot_p_angle,
    output logic signed [SLOT_W-1:0]      slot_q_angle,
    output logic signed [SLOT_W-1:0]      slot_p_mag,
    output logic signed [SLOT_W-1:0]      slot_q_mag
);

    localparam int VW = VALUE_WIDTH;
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

    typedef enum logic [2:0] {P_IDLE, P_MUL, P_ROUND, P_ACC, P_SQRT, P_DIV} phase_t;

    phase_t           phase_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;

    logic signed [VW-1:0] vir_reg, vii_reg, vjr_reg, vji_reg, yr_reg, yi_reg;
    logic signed [VW-1:0] nr_reg, ni_reg, wr_reg, wi_reg, ur_reg, ui_reg;
    logic signed [VW-1:0] ir_reg, ii_reg, v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [SLOT_W-1:0] pos0_reg, pos1_reg, pos2_reg, pos3_reg;
    logic                     type_reg;

    // multiplier and accumulator
    logic [MAW-1:0]          ma_reg;
    logic [VW-1:0]           mb_reg;
    logic                    msgn_reg, mraw_reg;
    acc_mode_t               mmode_reg;
    logic [PACC_W-1:0]       pacc_reg, pacc_next;
    logic [DIG+VW-1:0]       part;
    logic signed [PACC_W:0]  prod, prod_rnd, prod_sh;
    logic signed [ACC_W-1:0] rnd_reg, rnd_next, acc_reg;

    // square root
    logic [2*VW-1:0] rad_reg;
    logic [VW:0]     rem_reg;
    logic [VW-1:0]   root_reg, root_next, mag_reg;
    logic [VW+2:0]   rem_sh, trial;
    logic [VW:0]     rem_next;

    // divider
    logic [DV_W-1:0]      dd_reg, dsh_reg, dd_next;
    logic [QB-1:0]        q_reg, q_next;
    logic                 dsgn_reg;
    src_t                 ddst_reg;
    logic signed [VW-1:0] div_val;

    // register write port shared by stores and divider results
    logic                    wr_en;
    src_t                    wr_sel;
    logic signed [VW-1:0]    wr_val;
    logic signed [ACC_W-1:0] st_val;
    logic signed [VW:0]      cur_re, cur_im;

    logic                 issue;
    logic                 load_out;
    logic signed [VW-1:0] a_val, b_val;
    logic [VW-1:0]        a_abs, b_abs;

    function automatic logic signed [VW-1:0] sat_v(input logic signed [ACC_W-1:0] s);
        if (s > SAT_HI)
            return SAT_HI[VW-1:0];
        else if (s < SAT_LO)
            return SAT_LO[VW-1:0];
        else
            return s[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] src_val(input src_t s);
        logic signed [VW-1:0] v;
        unique case (s)
            SRC_VIR: v = vir_reg;
            SRC_VII: v = vii_reg;
            SRC_VJR: v = vjr_reg;
            SRC_VJI: v = vji_reg;
            SRC_YR:  v = yr_reg;
            SRC_YI:  v = yi_reg;
            SRC_NR:  v = nr_reg;
            SRC_NI:  v = ni_reg;
            SRC_WR:  v = wr_reg;
            SRC_WI:  v = wi_reg;
            SRC_UR:  v = ur_reg;
            SRC_UI:  v = ui_reg;
            SRC_IR:  v = ir_reg;
            SRC_II:  v = ii_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    assign issue    = cmd.go;
    assign load_out = issue && (cmd.op.kind == K_OUT);
    assign a_val    = src_val(cmd.op.a);
    assign b_val    = src_val(cmd.op.b);
    assign a_abs    = mag_of(a_val);
    assign b_abs    = mag_of(b_val);

    assign stat.busy     = (phase_reg != P_IDLE);
    assign stat.out_full = out_valid_reg && out_stall;

    always_comb
    begin
        part      = {{VW{1'b0}}, ma_reg[MAW-1 -: DIG]} * {{DIG{1'b0}}, mb_reg};
        pacc_next = (pacc_reg << DIG) + PACC_W'(part);

        prod     = msgn_reg ? -$signed({1'b0, pacc_reg}) : $signed({1'b0, pacc_reg});
        prod_rnd = prod + (PACC_W+1)'(1 << (FRAC - 1));
        prod_sh  = prod_rnd >>> FRAC;
        rnd_next = mraw_reg ? {prod[PACC_W], prod} : {prod_sh[PACC_W], prod_sh};

        rem_sh = {rem_reg, rad_reg[2*VW-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = (VW+1)'(rem_sh - trial);
            root_next = {root_reg[VW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = (VW+1)'(rem_sh);
            root_next = {root_reg[VW-2:0], 1'b0};
        end

        if (dd_reg >= dsh_reg)
        begin
            dd_next = dd_reg - dsh_reg;
            q_next  = {q_reg[QB-2:0], 1'b1};
        end
        else
        begin
            dd_next = dd_reg;
            q_next  = {q_reg[QB-2:0], 1'b0};
        end
        div_val = dsgn_reg ? -$signed(VW'(q_next)) : $signed(VW'(q_next));

        st_val = cmd.op.neg ? -acc_reg : acc_reg;
        cur_re = {ir_reg[VW-1], ir_reg} + {wr_reg[VW-1], wr_reg};
        cur_im = {ii_reg[VW-1], ii_reg} + {wi_reg[VW-1], wi_reg};

        if ((phase_reg == P_DIV) && (cnt_reg == CNT_W'(1)))
        begin
            wr_en  = 1'b1;
            wr_sel = ddst_reg;
            wr_val = div_val;
        end
        else
        begin
            wr_en  = issue && (cmd.op.kind == K_STORE);
            wr_sel = cmd.op.dst;
            wr_val = sat_v(st_val);
        end
    end

    // control state and row current
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            ir_reg        <= '0;
            ii_reg        <= '0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (issue)
            begin
                case (cmd.op.kind)
                    K_MUL:
                    begin
                        phase_reg <= P_MUL;
                        cnt_reg   <= CNT_W'(NDIG);
                    end
                    K_SQRT:
                    begin
                        phase_reg <= P_SQRT;
                        cnt_reg   <= CNT_W'(VW);
                    end
                    K_DIV:
                    begin
                        phase_reg <= P_DIV;
                        cnt_reg   <= CNT_W'(QB);
                    end
                    K_CUR:
                    begin
                        ir_reg <= sat_v(ACC_W'(cur_re));
                        ii_reg <= sat_v(ACC_W'(cur_im));
                    end
                    K_CLR:
                    begin
                        ir_reg <= '0;
                        ii_reg <= '0;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (phase_reg)
                    P_MUL, P_SQRT, P_DIV:
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1))
                            phase_reg <= (phase_reg == P_MUL) ? P_ROUND : P_IDLE;
                    end
                    P_ROUND: phase_reg <= P_ACC;
                    P_ACC:   phase_reg <= P_IDLE;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= req_type;
            vir_reg  <= vi_re;
            vii_reg  <= vi_im;
            vjr_reg  <= vj_re;
            vji_reg  <= vj_im;
            yr_reg   <= adm_re;
            yi_reg   <= adm_im;
            pos0_reg <= pos_p_angle;
            pos1_reg <= pos_q_angle;
            pos2_reg <= pos_p_mag;
            pos3_reg <= pos_q_mag;
        end

        if (issue && (cmd.op.kind == K_MUL))
        begin
            ma_reg    <= MAW'(a_abs);
            mb_reg    <= b_abs;
            msgn_reg  <= a_val[VW-1] ^ b_val[VW-1];
            mraw_reg  <= cmd.op.raw;
            mmode_reg <= cmd.op.mode;
            pacc_reg  <= '0;
        end
        if (issue && (cmd.op.kind == K_SQRT))
        begin
            rad_reg  <= acc_reg[2*VW-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (issue && (cmd.op.kind == K_DIV))
        begin
            // |c| * 2^FRAC + |V|/2, divisor aligned to the top quotient bit
            dd_reg   <= DV_W'({a_abs, {FRAC{1'b0}}}) + DV_W'(mag_reg[VW-1:1]);
            dsh_reg  <= DV_W'({mag_reg, {FRAC{1'b0}}});
            q_reg    <= '0;
            dsgn_reg <= a_val[VW-1];
            ddst_reg <= cmd.op.dst;
        end

        case (phase_reg)
            P_MUL:
            begin
                pacc_reg <= pacc_next;
                ma_reg   <= ma_reg << DIG;
            end
            P_ROUND: rnd_reg <= rnd_next;
            P_ACC:
            begin
                case (mmode_reg)
                    ACC_ADD: acc_reg <= acc_reg + rnd_reg;
                    ACC_SUB: acc_reg <= acc_reg - rnd_reg;
                    default: acc_reg <= rnd_reg;
                endcase
            end
            P_SQRT:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                if (cnt_reg == CNT_W'(1))
                    mag_reg <= (root_next < VW'(MAG_FLOOR)) ? VW'(MAG_FLOOR) : root_next;
            end
            P_DIV:
            begin
                dd_reg  <= dd_next;
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= q_next;
            end
            default: ;
        endcase

        if (wr_en)
        begin
            unique case (wr_sel)
                SRC_NR:  nr_reg <= wr_val;
                SRC_NI:  ni_reg <= wr_val;
                SRC_WR:  wr_reg <= wr_val;
                SRC_WI:  wi_reg <= wr_val;
                SRC_UR:  ur_reg <= wr_val;
                SRC_UI:  ui_reg <= wr_val;
                SRC_V0:  v0_reg <= wr_val;
                SRC_V1:  v1_reg <= wr_val;
                SRC_V2:  v2_reg <= wr_val;
                SRC_V3:  v3_reg <= wr_val;
                default: ;
            endcase
        end

        // negative slot: echo -1 with a zero value
        if (load_out)
        begin
            add_mode      <= type_reg;
            p_angle_value <= pos0_reg[SLOT_W-1] ? '0 : v0_reg;
            q_angle_value <= pos1_reg[SLOT_W-1] ? '0 : v1_reg;
            p_mag_value   <= pos2_reg[SLOT_W-1] ? '0 : v2_reg;
            q_mag_value   <= pos3_reg[SLOT_W-1] ? '0 : v3_reg;
            slot_p_angle  <= pos0_reg[SLOT_W-1] ? '1 : pos0_reg;
            slot_q_angle  <= pos1_reg[SLOT_W-1] ? '1 : pos1_reg;
            slot_p_mag    <= pos2_reg[SLOT_W-1] ? '1 : pos2_reg;
            slot_q_mag    <= pos3_reg[SLOT_W-1] ? '1 : pos3_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go |-> (phase_reg == P_IDLE))
        else $error("command issued while a unit is busy");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == P_MUL || phase_reg == P_SQRT || phase_reg == P_DIV) |-> (cnt_reg != '0))
        else $error("iteration counter ran out inside an iterative phase");

endmodule

### rtl/power_flow_jacobian_fill.sv
// Polar-form power-flow Jacobian fill: one result item per input item.
// Element items and row-end items run separate micro-op programs; item time is set
// by 16-bit digit-serial products, a 48-step square root and two 29-step divisions,
// sequenced one micro-op at a time. The next item is accepted the cycle after its
// predecessor's result is loaded into the output register.
// Reset (rst_n low, asynchronous) clears the row current, sequencer and output valid.
module power_flow_jacobian_fill
    import pfj_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic signed [VALUE_WIDTH-1:0] vi_re,
    input  logic signed [VALUE_WIDTH-1:0] vi_im,
    input  logic signed [VALUE_WIDTH-1:0] vj_re,
    input  logic signed [VALUE_WIDTH-1:0] vj_im,
    input  logic signed [VALUE_WIDTH-1:0] adm_re,
    input  logic signed [VALUE_WIDTH-1:0] adm_im,
    input  logic signed [SLOT_W-1:0]      pos_p_angle,
    input  logic signed [SLOT_W-1:0]      pos_q_angle,
    input  logic signed [SLOT_W-1:0]      pos_p_mag,
    input  logic signed [SLOT_W-1:0]      pos_q_mag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          add_mode,
    output logic signed [VALUE_WIDTH-1:0] p_angle_value,
    output logic signed [VALUE_WIDTH-1:0] q_angle_value,
    output logic signed [VALUE_WIDTH-1:0] p_mag_value,
    output logic signed [VALUE_WIDTH-1:0] q_mag_value,
    output logic signed [SLOT_W-1:0]      slot_p_angle,
    output logic signed [SLOT_W-1:0]      slot_q_angle,
    output logic signed [SLOT_W-1:0]      slot_p_mag,
    output logic signed [SLOT_W-1:0]      slot_q_mag
);

    cmd_t  cmd;
    stat_t stat;

    pfj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfj_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .vi_re         (vi_re),
        .vi_im         (vi_im),
        .vj_re         (vj_re),
        .vj_im         (vj_im),
        .adm_re        (adm_re),
        .adm_im        (adm_im),
        .pos_p_angle   (pos_p_angle),
        .pos_q_angle   (pos_q_angle),
        .pos_p_mag     (pos_p_mag),
        .pos_q_mag     (pos_q_mag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .add_mode      (add_mode),
        .p_angle_value (p_angle_value),
        .q_angle_value (q_angle_value),
        .p_mag_value   (p_mag_value),
        .q_mag_value   (q_mag_value),
        .slot_p_angle  (slot_p_angle),
        .slot_q_angle  (slot_q_angle),
        .slot_p_mag    (slot_p_mag),
        .slot_q_mag    (slot_q_mag)
    );

endmodule
